@@ src/feistel_datadep_rotate_cipher_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros used by the port-level checker file
// ----------------------------------------------------------------------------
`ifndef FEISTEL_DATADEP_ROTATE_CIPHER_MACROS_SVH
`define FEISTEL_DATADEP_ROTATE_CIPHER_MACROS_SVH

// consequence must hold in the cycle after the antecedent
`define FDRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define FDRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

`endif

@@ src/fdrc_pkg.sv @@
// ----------------------------------------------------------------------------
// fdrc_pkg
// types, constants and round functions of the data-dependent rotate cipher
// ----------------------------------------------------------------------------
`default_nettype none

package fdrc_pkg;

    localparam int ROUNDS_DEF = 16;
    localparam int KEY_WORDS  = 4;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT3     = 3'd5;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // words that stand in for missing key words
    localparam logic [31:0] FILL_WORDS [8] = '{
        32'd707106788, 32'd866025405, 32'd559116991, 32'd661437827,
        32'd357247820, 32'd120784366, 32'd587496123, 32'd154786201
    };

    typedef logic [3:0][4:0] rot_set_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_CRYPT,
        ST_WAIT
    } state_t;

    // bits 1, 3, 7, 15, 31, msb first
    function automatic logic [4:0] pick_bits(input logic [31:0] v);
        return {v[1], v[3], v[7], v[15], v[31]};
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] left, input logic [31:0] key,
                                        input rot_set_t rot);
        logic [31:0] sum;
        logic [4:0]  a;
        logic [4:0]  b;
        logic [1:0]  sel;
        logic [63:0] dbl;
        sum    = left + key;
        a      = pick_bits(sum);
        b      = pick_bits(left);
        // an a of zero picks no bit of left and reads as zero
        sel[1] = (a != 5'd0) & left[a];
        sel[0] = sum[b];
        dbl    = {sum, sum} >> rot[sel];
        return dbl[31:0];
    endfunction

    function automatic logic [31:0] seed_word(input logic [2:0] j, input logic [63:0] klo,
                                              input logic [63:0] khi);
        logic [3:0][31:0] w;
        w = {khi, klo};
        if (int'(j) < KEY_WORDS) begin
            return w[j[1:0]];
        end else begin
            return FILL_WORDS[3'(int'(j) - KEY_WORDS)];
        end
    endfunction

endpackage

`default_nettype wire

@@ src/feistel_datadep_rotate_cipher.sv @@
// ----------------------------------------------------------------------------
// feistel_datadep_rotate_cipher
// 64-bit feistel block cipher with data-dependent rotation and stored key schedule
// ----------------------------------------------------------------------------
// Items are taken one at a time, only in the idle state: the acceptance cycle
// issues the first round key read, then one shared round unit runs one round
// per cycle, fed from the round key ram, whose registered read port is
// addressed with the next round's key. The result lands in an output register,
// so a stalled result does not block the next item until its last round. After
// a write to a defined register the first item waits while the key schedule is
// rebuilt into the ram, one round key per cycle through the same round unit. A
// configuration write offered together with an item goes first.
`default_nettype none

module feistel_datadep_rotate_cipher #(
    parameter int ROUNDS = fdrc_pkg::ROUNDS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,   // left_in[31:0], right_in[63:32]
    input  wire logic                           s_tuser,   // command
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [63:0]                    m_tdata,   // left_out[31:0], right_out[63:32]
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fdrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data
);

    localparam int AW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [AW-1:0] LAST_RND = AW'(ROUNDS - 1);

    fdrc_pkg::state_t   state_reg, state_next;
    logic               sched_valid_reg, sched_valid_next;
    logic               out_valid_reg, out_valid_next;

    logic [63:0]        key_low_reg, key_low_next;
    logic [63:0]        key_high_reg, key_high_next;
    fdrc_pkg::rot_set_t rot_reg, rot_next;
    logic [31:0]        left_reg, left_next;
    logic [31:0]        right_reg, right_next;
    logic               dec_reg, dec_next;
    logic [AW-1:0]      rnd_reg, rnd_next;
    logic [AW-1:0]      kaddr_reg, kaddr_next;
    logic [2:0]         mod_reg, mod_next;
    logic [31:0]        out_left_reg, out_left_next;
    logic [31:0]        out_right_reg, out_right_next;

    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    logic               last_rnd;
    logic               tail_form;
    logic               dec_form;
    logic [31:0]        round_src;
    logic [31:0]        round_other;
    logic [31:0]        round_key;
    logic [31:0]        sched_key;
    logic [31:0]        round_f;
    logic [31:0]        res_left;
    logic [31:0]        res_right;
    logic [AW-1:0]      kaddr_step;
    logic [AW-1:0]      first_addr;
    logic               out_free;

    fdrc_ram #(
        .WIDTH (32),
        .DEPTH (ROUNDS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (rnd_reg),
        .wr_data (round_f),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // shared round unit
    always_comb begin
        last_rnd    = (rnd_reg == LAST_RND);
        // round without swap: last of encryption, first of decryption
        tail_form   = (state_reg == fdrc_pkg::ST_CRYPT) &&
                      (dec_reg ? (rnd_reg == '0) : last_rnd);
        dec_form    = (state_reg == fdrc_pkg::ST_CRYPT) && dec_reg && (rnd_reg != '0);
        round_src   = dec_form ? right_reg : left_reg;
        round_other = dec_form ? left_reg : right_reg;
        sched_key   = (32'(rnd_reg) + 32'd1) ^
                      fdrc_pkg::seed_word(3'(mod_reg + 3'd2), key_low_reg, key_high_reg);
        round_key   = (state_reg == fdrc_pkg::ST_SCHED) ? sched_key : ram_rdata;
        round_f     = fdrc_pkg::mix(round_src, round_key, rot_reg) ^ round_other;
        if (tail_form) begin
            res_left  = left_reg;
            res_right = round_f;
        end else if (dec_form) begin
            res_left  = right_reg;
            res_right = round_f;
        end else begin
            res_left  = round_f;
            res_right = left_reg;
        end
        kaddr_step = dec_reg ? (kaddr_reg - AW'(1)) : (kaddr_reg + AW'(1));
        first_addr = (s_tuser == fdrc_pkg::CMD_DECRYPT) ? LAST_RND : '0;
        ram_raddr  = (state_reg == fdrc_pkg::ST_IDLE) ? first_addr : kaddr_step;
    end

    always_comb begin
        state_next       = state_reg;
        sched_valid_next = sched_valid_reg;
        out_valid_next   = out_valid_reg;
        key_low_next     = key_low_reg;
        key_high_next    = key_high_reg;
        rot_next         = rot_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        dec_next         = dec_reg;
        rnd_next         = rnd_reg;
        kaddr_next       = kaddr_reg;
        mod_next         = mod_reg;
        out_left_next    = out_left_reg;
        out_right_next   = out_right_reg;
        ram_we           = 1'b0;

        s_tready  = (state_reg == fdrc_pkg::ST_IDLE) && sched_valid_reg && !cfg_valid;
        cfg_ready = (state_reg == fdrc_pkg::ST_IDLE);
        out_free  = !out_valid_reg || m_tready;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fdrc_pkg::ST_IDLE: begin
                if (cfg_valid) begin
                    sched_valid_next = 1'b0;
                    unique case (cfg_index)
                        fdrc_pkg::CFG_KEY_LOW:  key_low_next  = cfg_data;
                        fdrc_pkg::CFG_KEY_HIGH: key_high_next = cfg_data;
                        fdrc_pkg::CFG_ROT0:     rot_next[0]   = cfg_data[4:0];
                        fdrc_pkg::CFG_ROT1:     rot_next[1]   = cfg_data[4:0];
                        fdrc_pkg::CFG_ROT2:     rot_next[2]   = cfg_data[4:0];
                        fdrc_pkg::CFG_ROT3:     rot_next[3]   = cfg_data[4:0];
                        // unknown register: ignored, schedule validity unchanged
                        default:                sched_valid_next = sched_valid_reg;
                    endcase
                end
                if (s_tvalid && s_tready) begin
                    left_next  = s_tdata[31:0];
                    right_next = s_tdata[63:32];
                    dec_next   = (s_tuser == fdrc_pkg::CMD_DECRYPT);
                    rnd_next   = '0;
                    kaddr_next = first_addr;
                    state_next = fdrc_pkg::ST_CRYPT;
                end else if (s_tvalid && !sched_valid_reg && !cfg_valid) begin
                    left_next  = fdrc_pkg::seed_word(3'd0, key_low_reg, key_high_reg);
                    right_next = fdrc_pkg::seed_word(3'd1, key_low_reg, key_high_reg);
                    rnd_next   = '0;
                    mod_next   = 3'd1;
                    state_next = fdrc_pkg::ST_SCHED;
                end
            end
            fdrc_pkg::ST_SCHED: begin
                ram_we     = 1'b1;
                left_next  = res_left;
                right_next = res_right;
                if (last_rnd) begin
                    sched_valid_next = 1'b1;
                    state_next       = fdrc_pkg::ST_IDLE;
                end else begin
                    rnd_next = rnd_reg + AW'(1);
                    mod_next = (mod_reg == 3'd5) ? 3'd0 : (mod_reg + 3'd1);
                end
            end
            fdrc_pkg::ST_CRYPT: begin
                left_next  = res_left;
                right_next = res_right;
                if (last_rnd) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_left_next  = res_left;
                        out_right_next = res_right;
                        state_next     = fdrc_pkg::ST_IDLE;
                    end else begin
                        state_next = fdrc_pkg::ST_WAIT;
                    end
                end else begin
                    rnd_next   = rnd_reg + AW'(1);
                    kaddr_next = kaddr_step;
                end
            end
            fdrc_pkg::ST_WAIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_left_next  = left_reg;
                    out_right_next = right_reg;
                    state_next     = fdrc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fdrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fdrc_pkg::ST_IDLE;
            sched_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            key_low_reg     <= '0;
            key_high_reg    <= '0;
            rot_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            sched_valid_reg <= sched_valid_next;
            out_valid_reg   <= out_valid_next;
            key_low_reg     <= key_low_next;
            key_high_reg    <= key_high_next;
            rot_reg         <= rot_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg      <= left_next;
        right_reg     <= right_next;
        dec_reg       <= dec_next;
        rnd_reg       <= rnd_next;
        kaddr_reg     <= kaddr_next;
        mod_reg       <= mod_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};

endmodule

`default_nettype wire

@@ src/fdrc_ram.sv @@
// ----------------------------------------------------------------------------
// fdrc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fdrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/fdrc_checker.sv @@
// ----------------------------------------------------------------------------
// fdrc_checker
// port-level checks on the data-dependent rotate cipher, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "feistel_datadep_rotate_cipher_macros.svh"

module fdrc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [63:0]                    s_tdata,
    input wire logic                           s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [63:0]                    m_tdata,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready,
    input wire logic [fdrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [63:0]                    cfg_data
);

    logic in_item;
    logic cfg_write;

    assign in_item   = s_tvalid && s_tready && (s_tuser || !s_tuser);
    assign cfg_write = cfg_valid && cfg_ready && (cfg_data == cfg_data);

    // a stalled result holds
    `FDRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one item at a time: no new item right after one is taken
    `FDRC_ASSERT_NEXT(a_one_at_a_time, in_item && (s_tdata == s_tdata), !s_tready, "item accepted while busy")

    // a result never shows up the cycle after an item is taken
    `FDRC_ASSERT_NEXT(a_no_instant_result, in_item, !$rose(m_tvalid), "result appeared too early")

    // a key or rotation write forces a schedule rebuild before the next item
    `FDRC_ASSERT_NEXT(a_cfg_rebuild, cfg_write && (cfg_index <= fdrc_pkg::CFG_ROT3), !s_tready, "item taken with stale key schedule")

    // input is only taken while the block is idle and takes configuration
    `FDRC_ASSERT_NOW(a_ready_idle, s_tready, cfg_ready, "input ready outside idle")

endmodule

bind feistel_datadep_rotate_cipher fdrc_checker u_fdrc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

`default_nettype wire

@@ dv/feistel_datadep_rotate_cipher_checker.sv @@
// ----------------------------------------------------------------------------
// feistel_datadep_rotate_cipher_checker
// watches the config, input and result channels of the cipher, keeps its own
// key schedule and rotation settings, predicts every result block and compares
// it field by field with what the block delivers
// ----------------------------------------------------------------------------
module feistel_datadep_rotate_cipher_checker #(
    parameter int ROUNDS = fdrc_pkg::ROUNDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [63:0]                    s_tdata,   // left_in[31:0], right_in[63:32]
    input  logic                           s_tuser,   // command
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [63:0]                    m_tdata,   // left_out[31:0], right_out[63:32]
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [fdrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    output int                             errors,
    output int                             pending
);

    typedef struct {
        logic [31:0] left_out;
        logic [31:0] right_out;
    } cipher_block_t;

    cipher_block_t expected_blocks[$];

    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  rot_amt [4];
    logic [31:0] round_keys [ROUNDS];
    logic        keys_stale;

    // bits 1, 3, 7, 15 and 31 of the word, first one ends up on top
    function automatic logic [4:0] tap_bits(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 1; i <= 5; i++) begin
            idx[5-i] = v[(1 << i) - 1];
        end
        return idx;
    endfunction

    function automatic logic [31:0] rotate_right(input logic [31:0] v, input logic [4:0] s);
        if (s == 5'd0) begin
            return v;
        end
        return (v >> s) | (v << (32 - int'(s)));
    endfunction

    function automatic logic [31:0] round_mix(input logic [31:0] left, input logic [31:0] key);
        logic [31:0] sum;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [4:0]  a;
        logic [4:0]  b;
        logic [1:0]  sel;
        sum = left + key;
        a   = tap_bits(sum);
        // a of zero wraps the shift to 31, so bit 1 of the shifted word is always zero
        hi  = (left >> ((32'(a) - 32'd1) & 32'd31)) & 32'h2;
        b   = tap_bits(left);
        lo  = (sum >> b) & 32'h1;
        sel = 2'(hi + lo);
        return rotate_right(sum, rot_amt[sel]);
    endfunction

    task automatic rebuild_round_keys();
        logic [31:0] seed [8];
        logic [31:0] words [4];
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] nx0;
        words[0] = key_lo[31:0];
        words[1] = key_lo[63:32];
        words[2] = key_hi[31:0];
        words[3] = key_hi[63:32];
        for (int i = 0; i < 8; i++) begin
            seed[i] = (i < fdrc_pkg::KEY_WORDS) ? words[i % 4]
                                                : fdrc_pkg::FILL_WORDS[(i - fdrc_pkg::KEY_WORDS) % 8];
        end
        x0 = seed[0];
        x1 = seed[1];
        for (int i = 1; i <= ROUNDS; i++) begin
            nx0 = round_mix(x0, 32'(i) ^ seed[(i % 6) + 2]) ^ x1;
            x1  = x0;
            x0  = nx0;
            round_keys[i-1] = x0;
        end
        keys_stale = 1'b0;
    endtask

    function automatic cipher_block_t cipher_block(input logic cmd, input logic [31:0] l_in,
                                                   input logic [31:0] r_in);
        cipher_block_t res;
        logic [31:0]   l;
        logic [31:0]   r;
        logic [31:0]   t;
        l = l_in;
        r = r_in;
        if (cmd == fdrc_pkg::CMD_ENCRYPT) begin
            for (int i = 0; i < ROUNDS - 1; i++) begin
                t = round_mix(l, round_keys[i]) ^ r;
                r = l;
                l = t;
            end
            r = round_mix(l, round_keys[ROUNDS-1]) ^ r;
        end else begin
            r = round_mix(l, round_keys[ROUNDS-1]) ^ r;
            for (int i = ROUNDS - 2; i >= 0; i--) begin
                t = r;
                r = round_mix(r, round_keys[i]) ^ l;
                l = t;
            end
        end
        res.left_out  = l;
        res.right_out = r;
        return res;
    endfunction

    always @(posedge aclk) begin
        cipher_block_t exp_blk;
        int            err_cnt;
        err_cnt = errors;
        if (!aresetn) begin
            err_cnt    = 0;
            key_lo     = '0;
            key_hi     = '0;
            rot_amt    = '{default: '0};
            keys_stale = 1'b1;
            expected_blocks.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fdrc_pkg::CFG_KEY_LOW: begin
                        key_lo = cfg_data;
                        keys_stale = 1'b1;
                    end
                    fdrc_pkg::CFG_KEY_HIGH: begin
                        key_hi = cfg_data;
                        keys_stale = 1'b1;
                    end
                    fdrc_pkg::CFG_ROT0, fdrc_pkg::CFG_ROT1,
                    fdrc_pkg::CFG_ROT2, fdrc_pkg::CFG_ROT3: begin
                        rot_amt[cfg_index - fdrc_pkg::CFG_ROT0] = cfg_data[4:0];
                        keys_stale = 1'b1;
                    end
                    default: ; // spare index, nothing changes
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (keys_stale) begin
                    rebuild_round_keys();
                end
                expected_blocks.push_back(cipher_block(s_tuser, s_tdata[31:0], s_tdata[63:32]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    $error("result item with nothing expected: %h", m_tdata);
                    err_cnt++;
                end else begin
                    exp_blk = expected_blocks.pop_front();
                    if (m_tdata[31:0] !== exp_blk.left_out) begin
                        $error("left_out mismatch: expected %h, actual %h",
                               exp_blk.left_out, m_tdata[31:0]);
                        err_cnt++;
                    end
                    if (m_tdata[63:32] !== exp_blk.right_out) begin
                        $error("right_out mismatch: expected %h, actual %h",
                               exp_blk.right_out, m_tdata[63:32]);
                        err_cnt++;
                    end
                end
            end
        end
        errors  <= err_cnt;
        pending <= expected_blocks.size();
    end

endmodule

@@ dv/feistel_datadep_rotate_cipher_tb.sv @@
// ----------------------------------------------------------------------------
// feistel_datadep_rotate_cipher_tb
// drives encrypt and decrypt items through the cipher under a series of key
// and rotation settings, directed extremes first and random blocks after,
// with random gaps on both channels and one long result back-pressure stretch;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module feistel_datadep_rotate_cipher_tb;

    typedef logic [fdrc_pkg::CFG_IDX_W-1:0] cfg_idx_t;

    localparam int ROUNDS      = fdrc_pkg::ROUNDS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // indexes past the last register, the block must ignore them
    localparam cfg_idx_t CFG_SPARE_LO = 3'd6;
    localparam cfg_idx_t CFG_SPARE_HI = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    int errors;
    int pending;
    int cycles   = 0;
    bit gaps_off = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    feistel_datadep_rotate_cipher #(.ROUNDS(ROUNDS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    feistel_datadep_rotate_cipher_checker #(.ROUNDS(ROUNDS)) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_half();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_key();
        case ($urandom_range(0, 7))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] rand_rot();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       v[4:0] = 5'd0;
            1:       v[4:0] = 5'd31;
            default: ;
        endcase
        return v;
    endfunction

    // valid stays high from one item to the next when there is no gap
    task automatic push_block(input logic cmd, input logic [31:0] l, input logic [31:0] r);
        int gap;
        gap = gaps_off ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // block idle: no item offered, every result back, pipeline drained
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (ROUNDS + 4) @(posedge aclk);
    endtask

    task automatic random_settings(input int phase);
        cfg_idx_t idx;
        case (phase)
            0: begin
                write_reg(fdrc_pkg::CFG_KEY_LOW, 64'h0);
                write_reg(fdrc_pkg::CFG_KEY_HIGH, 64'h0);
                for (int i = 0; i < 4; i++) write_reg(cfg_idx_t'(fdrc_pkg::CFG_ROT0 + i), 64'h0);
            end
            1: begin
                write_reg(fdrc_pkg::CFG_KEY_LOW, '1);
                write_reg(fdrc_pkg::CFG_KEY_HIGH, '1);
                for (int i = 0; i < 4; i++) write_reg(cfg_idx_t'(fdrc_pkg::CFG_ROT0 + i), '1);
            end
            default: begin
                write_reg(fdrc_pkg::CFG_KEY_LOW, rand_key());
                if ($urandom_range(0, 1)) write_reg(fdrc_pkg::CFG_KEY_HIGH, rand_key());
                for (int i = 0; i < 4; i++) begin
                    idx = cfg_idx_t'(fdrc_pkg::CFG_ROT0 + i);
                    if ($urandom_range(0, 2) != 0) write_reg(idx, rand_rot());
                end
                if ($urandom_range(0, 3) == 0) begin
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                              {$urandom, $urandom});
                end
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero keys, no rotation
        gaps_off = 1'b1;
        push_block(fdrc_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        push_block(fdrc_pkg::CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        push_block(fdrc_pkg::CMD_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
        push_block(fdrc_pkg::CMD_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
        settle();

        // all ones everywhere
        write_reg(fdrc_pkg::CFG_KEY_LOW, '1);
        write_reg(fdrc_pkg::CFG_KEY_HIGH, '1);
        write_reg(fdrc_pkg::CFG_ROT0, 64'd31);
        write_reg(fdrc_pkg::CFG_ROT1, 64'd31);
        write_reg(fdrc_pkg::CFG_ROT2, 64'd31);
        write_reg(fdrc_pkg::CFG_ROT3, 64'd31);
        cfg_valid <= 1'b0;
        gaps_off = 1'b0;
        push_block(fdrc_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
        push_block(fdrc_pkg::CMD_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
        push_block(fdrc_pkg::CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        push_block(fdrc_pkg::CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        push_block(fdrc_pkg::CMD_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
        push_block(fdrc_pkg::CMD_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
        settle();

        // distinct amounts, one of them the identity rotation
        write_reg(fdrc_pkg::CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(fdrc_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(fdrc_pkg::CFG_ROT0, 64'd0);
        write_reg(fdrc_pkg::CFG_ROT1, 64'd1);
        write_reg(fdrc_pkg::CFG_ROT2, 64'd16);
        write_reg(fdrc_pkg::CFG_ROT3, 64'd31);
        cfg_valid <= 1'b0;
        push_block(fdrc_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        push_block(fdrc_pkg::CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        push_block(fdrc_pkg::CMD_ENCRYPT, 32'h0000_0001, 32'hffff_fffe);
        push_block(fdrc_pkg::CMD_DECRYPT, $urandom, $urandom);
        push_block(fdrc_pkg::CMD_ENCRYPT, $urandom, $urandom);
        settle();

        // spare indexes leave the settings alone
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        push_block(fdrc_pkg::CMD_ENCRYPT, $urandom, $urandom);
        push_block(fdrc_pkg::CMD_DECRYPT, $urandom, $urandom);
        push_block(fdrc_pkg::CMD_ENCRYPT, 32'h7fff_ffff, 32'h8000_0000);

        for (int phase = 0; phase < 8; phase++) begin
            settle();
            random_settings(phase);
            gaps_off = (phase == 3);
            if (phase == 3) begin
                hold_req <= 1'b1;
            end
            repeat (50) push_block(1'($urandom_range(0, 1)), rand_half(), rand_half());
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4 * ROUNDS) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: random ready runs and stalls, one long hold while items keep coming
    initial begin
        int run;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
            end else begin
                run = idle_len();
                if (run > 0) begin
                    m_tready <= 1'b0;
                    repeat (run) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
            repeat (run) @(posedge aclk);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
